// ----- design/arp_pkg.sv -----
// angle report parser package: beat types, codes, prefix text and command bytes
// no dependencies; imported by every module of the parser
`timescale 1ns / 1ps

package arp_pkg;

  // number of microphones, a beam number at or above it sends no command
  localparam int unsigned MIC_COUNT = 4;

  localparam logic [8:0] ANGLE_MAX   = 9'd360;
  localparam logic [1:0] BEAM_RESET  = 2'd3;
  localparam int unsigned CMD_LEN    = 7;
  localparam int unsigned PREFIX_LEN = 6;

  // input opcodes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_TX     = 1'b1;

  // matcher positions: 1..5 prefix matched so far, 6..8 capturing
  localparam logic [3:0] POS_IDLE = 4'd0;
  localparam logic [3:0] POS_PFX5 = 4'd5;
  localparam logic [3:0] POS_CAP0 = 4'd6;
  localparam logic [3:0] POS_CAP1 = 4'd7;
  localparam logic [3:0] POS_CAP2 = 4'd8;

  localparam logic [7:0] PREFIX [PREFIX_LEN] = '{"a", "n", "g", "l", "e", ":"};

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [8:0] angle;
    logic       wake;
    logic       last;
  } out_t;

  // work handed from the front end to the result stage
  typedef struct packed {
    logic       valid;
    logic       is_read;
    logic [8:0] angle;
    logic       wake;
    logic [1:0] beam;
  } ev_t;

  // byte idx of the "BEAM n\n" command
  function automatic logic [7:0] cmd_byte(input logic [2:0] idx, input logic [1:0] beam);
    logic [7:0] b;
    case (idx)
      3'd0:    b = "B";
      3'd1:    b = "E";
      3'd2:    b = "A";
      3'd3:    b = "M";
      3'd4:    b = " ";
      3'd5:    b = 8'("0") + {6'd0, beam};
      default: b = 8'h0a;
    endcase
    return b;
  endfunction

endpackage

// ----- design/arp_front.sv -----
// input register, prefix matcher, three-character converter, angle and wake state
// depends on arp_pkg
`timescale 1ns / 1ps

module arp_front #(
  parameter int unsigned MIC_COUNT = arp_pkg::MIC_COUNT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  arp_pkg::in_t  in_data,
  input  logic [1:0]    beam_select,
  input  logic          out_free,
  output arp_pkg::ev_t  ev
);
  import arp_pkg::*;

  logic       q_valid;
  in_t        q_data;
  logic [3:0] match_position;
  logic [3:0] match_position_next;
  logic [7:0] cap0;
  logic [7:0] cap1;
  logic [8:0] stored_angle;
  logic       wake_flag;

  logic       is_read;
  logic       completes;
  logic       beam_present;
  logic       needs_out;
  logic       go;
  logic [7:0] txt [3];
  logic [9:0] conv_val;
  logic       conv_neg;
  logic [1:0] phase;
  logic       conv_ok;

  // item handling and backpressure
  assign is_read      = (q_data.opcode == OP_READ);
  assign completes    = !is_read && (match_position == POS_CAP2);
  assign beam_present = ({2'd0, beam_select} < 4'(MIC_COUNT));
  assign needs_out    = is_read || (completes && beam_present);
  assign go           = q_valid && (!needs_out || out_free);
  assign in_ready     = !q_valid || go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_data <= in_data;
    end
  end

  // prefix matcher
  always_comb begin
    match_position_next = match_position;
    if (match_position == POS_IDLE || match_position > POS_CAP2) begin
      match_position_next = (q_data.rx_byte == PREFIX[0]) ? 4'd1 : POS_IDLE;
    end else if (match_position <= POS_PFX5) begin
      if (q_data.rx_byte == PREFIX[match_position[2:0]]) begin
        match_position_next = match_position + 4'd1;
      end else begin
        match_position_next = POS_IDLE;
      end
    end else if (match_position == POS_CAP0 || match_position == POS_CAP1) begin
      match_position_next = match_position + 4'd1;
    end else begin
      match_position_next = POS_IDLE;
    end
  end

  // text to number: blanks, optional sign, then digits, three characters at most
  always_comb begin
    txt[0]   = cap0;
    txt[1]   = cap1;
    txt[2]   = q_data.rx_byte;
    conv_val = '0;
    conv_neg = 1'b0;
    phase    = 2'd0;
    for (int k = 0; k < 3; k++) begin
      if (phase == 2'd0) begin
        if (txt[k] inside {8'h20, [8'h09:8'h0d]}) begin
          phase = 2'd0;
        end else if (txt[k] == "+" || txt[k] == "-") begin
          conv_neg = (txt[k] == "-");
          phase    = 2'd1;
        end else if (txt[k] inside {["0":"9"]}) begin
          conv_val = 10'(txt[k] - 8'("0"));
          phase    = 2'd1;
        end else begin
          phase = 2'd2;
        end
      end else if (phase == 2'd1) begin
        if (txt[k] inside {["0":"9"]}) begin
          conv_val = 10'(conv_val * 10'd10) + 10'(txt[k] - 8'("0"));
        end else begin
          phase = 2'd2;
        end
      end
    end
    conv_ok = !(conv_neg && conv_val != 10'd0) && (conv_val <= {1'b0, ANGLE_MAX});
  end

  // matcher position and report state
  always_ff @(posedge clk) begin
    if (rst) begin
      match_position <= POS_IDLE;
      stored_angle   <= '0;
      wake_flag      <= 1'b0;
    end else if (go) begin
      if (is_read) begin
        wake_flag <= 1'b0;
      end else begin
        match_position <= match_position_next;
        if (completes) begin
          wake_flag <= 1'b1;
          if (conv_ok) begin
            stored_angle <= conv_val[8:0];
          end
        end
      end
    end
  end

  // captured characters
  always_ff @(posedge clk) begin
    if (go && !is_read) begin
      if (match_position == POS_CAP0) begin
        cap0 <= q_data.rx_byte;
      end
      if (match_position == POS_CAP1) begin
        cap1 <= q_data.rx_byte;
      end
    end
  end

  // hand-off to the result stage
  always_comb begin
    ev.valid   = go && needs_out;
    ev.is_read = is_read;
    ev.angle   = stored_angle;
    ev.wake    = wake_flag;
    ev.beam    = beam_select;
  end

endmodule

// ----- design/arp_tx.sv -----
// result register and command byte sequencer
// depends on arp_pkg
`timescale 1ns / 1ps

module arp_tx (
  input  logic          clk,
  input  logic          rst,
  input  arp_pkg::ev_t  ev,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_ready,
  output arp_pkg::out_t out_data
);
  import arp_pkg::*;

  logic [2:0] cmd_idx;
  logic [1:0] beam;

  // stage can take new work once the final beat leaves
  assign out_free = !out_valid || (out_ready && out_data.last);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cmd_idx   <= '0;
    end else if (ev.valid) begin
      out_valid <= 1'b1;
      cmd_idx   <= 3'd1;
    end else if (out_valid && out_ready) begin
      if (out_data.last) begin
        out_valid <= 1'b0;
      end else begin
        cmd_idx <= cmd_idx + 3'd1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ev.valid) begin
      beam <= ev.beam;
      if (ev.is_read) begin
        out_data <= '{kind: KIND_REPORT, tx_byte: 8'd0, angle: ev.angle,
                      wake: ev.wake, last: 1'b1};
      end else begin
        out_data <= '{kind: KIND_TX, tx_byte: cmd_byte(3'd0, ev.beam), angle: 9'd0,
                      wake: 1'b0, last: 1'b0};
      end
    end else if (out_valid && out_ready && !out_data.last) begin
      out_data <= '{kind: KIND_TX, tx_byte: cmd_byte(cmd_idx, beam), angle: 9'd0,
                    wake: 1'b0, last: (cmd_idx == 3'(CMD_LEN - 1))};
    end
  end

endmodule

// ----- design/angle_report_parser.sv -----
// angle report parser top level: beam register, front end and result stage
// depends on arp_pkg, arp_front, arp_tx
`timescale 1ns / 1ps

// Each beat goes into an input register and is handled from there, and its
// result is registered in the result stage; one beat can be taken per cycle
// while nothing stalls. A read gives one report beat; a byte that completes
// "angle:xyz" gives the seven beats of "BEAM n\n" (none when the beam number is
// not below the microphone count). The single result register sets the limit:
// while it still holds beats, bytes that give no result keep flowing, but a
// read or another completing byte waits until the final beat is taken. beam_select
// is written at any cycle with cfg_we and takes effect on the next command.

module angle_report_parser #(
  parameter int unsigned MIC_COUNT = arp_pkg::MIC_COUNT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  arp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output arp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata
);
  import arp_pkg::*;

  logic [1:0] beam_select;
  logic       out_free;
  ev_t        ev;

  // beam number register
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_select <= BEAM_RESET;
    end else if (cfg_we) begin
      beam_select <= cfg_wdata;
    end
  end

  arp_front #(
    .MIC_COUNT (MIC_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .beam_select (beam_select),
    .out_free    (out_free),
    .ev          (ev)
  );

  arp_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .ev        (ev),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a report answer is always a single beat
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_REPORT |-> out_data.last)
    else $error("report beat without last");

  // the final transmit beat is the newline
  a_cmd_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_TX && out_data.last |-> out_data.tx_byte == 8'h0a)
    else $error("command does not end in newline");

  // the stored angle stays in range
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.angle <= ANGLE_MAX)
    else $error("angle out of range");

  // input stalls only behind pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result stage");

  // new work after a non-final beat is not started
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last && !out_ready |=> out_valid && $stable(out_data))
    else $error("result overwritten before taken");

endmodule
